FILE: rtl/core/olam_pkg.sv
`timescale 1ns / 1ps

package olam_pkg;

    localparam int OLAM_DEPTH = 16;

    typedef logic signed [31:0] t_word;

    // operation codes
    localparam logic [1:0] FN_APPEND = 2'd0;
    localparam logic [1:0] FN_REMOVE = 2'd1;
    localparam logic [1:0] FN_DUMP   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [1:0] func;
        t_word      value;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        t_word      entry;
        logic [4:0] occupancy;
        logic       last;
    } t_rsp;

    // per-cycle commands broadcast along the cell row
    typedef struct packed {
        logic cap;  // capture compare result against incoming value
        logic wr;   // write incoming value into the tail cell
        logic rm;   // close the gap behind the first match
        logic rot;  // rotate the row one step toward the head
    } t_cell_ctl;

endpackage

FILE: rtl/core/olam_cell.sv
`timescale 1ns / 1ps

module olam_cell
    import olam_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_sel,    // this cell sits at the tail position
    input  t_word     i_wdata,
    input  t_word     i_nxt,    // neighbor toward the tail
    input  logic      i_hit,    // a match exists nearer the head
    output t_word     o_data,
    output logic      o_hit
);

    t_word r_data;
    logic  r_hit;

    assign o_data = r_data;
    assign o_hit  = i_hit | r_hit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cap) begin
            r_hit <= (r_data == i_wdata);
        end
        if (i_ctl.wr && i_sel) begin
            r_data <= i_wdata;
        end else if (i_ctl.rot || (i_ctl.rm && o_hit)) begin
            r_data <= i_nxt;
        end
    end

endmodule

FILE: rtl/core/ordered_list_append_delete_match_top.sv
`timescale 1ns / 1ps
// Ordered list of up to DEPTH signed values held in a row of cells.
// A request is accepted in idle; the execute state loads its response once
// the response slot is free. A dump sends its entries out one per free
// response slot, paced by the response register.
// Reset (sync, active low) empties the list and drops any pending response.
module ordered_list_append_delete_match_top
    import olam_pkg::*;
#(
    parameter int DEPTH = OLAM_DEPTH
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DUMP = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [1:0]       r_func;
    t_word            r_val;
    logic             r_rsp_valid, n_rsp_valid;
    t_rsp             r_rsp, n_rsp;

    t_cell_ctl        w_ctl;
    t_word            w_data [DEPTH];
    t_word            w_nxt  [DEPTH];
    logic [DEPTH:0]   w_hit;
    logic             w_acc;
    logic             w_free;
    logic             w_full;
    logic             w_empty;
    logic             w_dump_last;

    assign w_acc       = i_req_valid && o_req_ready;
    // response slot can take a new request result this cycle
    assign w_free      = !r_rsp_valid || i_rsp_ready;
    assign w_full      = (r_count == CNT_W'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_dump_last = (r_idx == r_count - CNT_W'(1));

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // Cell row: cell 0 is the head. Each cell takes its neighbor toward the
    // tail; the last held entry takes the head, which makes a dump a rotation
    // that leaves the list in order once every entry has gone out.
    assign w_hit[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == DEPTH - 1) begin : g_end
            assign w_nxt[g] = w_data[0];
        end else begin : g_mid
            assign w_nxt[g] = (CNT_W'(g) == r_count - CNT_W'(1)) ? w_data[0]
                                                                 : w_data[g + 1];
        end

        olam_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_sel   (CNT_W'(g) == r_count),
            // compare uses the incoming value on accept, later the held copy
            .i_wdata (w_acc ? i_req.value : r_val),
            .i_nxt   (w_nxt[g]),
            .i_hit   (w_hit[g]),
            .o_data  (w_data[g]),
            .o_hit   (w_hit[g + 1])
        );
    end

    // Control: execute stage resolves the request once the response slot is
    // free; dump walks the row one entry per free slot.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        w_ctl       = '0;
        w_ctl.cap   = w_acc;

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_free) begin
                    n_state        = S_IDLE;
                    n_rsp.status   = ST_OK;
                    n_rsp.entry    = '0;
                    n_rsp.last     = 1'b1;
                    n_rsp_valid    = 1'b1;
                    case (r_func)
                        FN_APPEND: begin
                            if (w_full) begin
                                n_rsp.status = ST_FULL;
                            end else begin
                                w_ctl.wr = 1'b1;
                                n_count  = r_count + CNT_W'(1);
                            end
                        end
                        FN_REMOVE: begin
                            // only cells below the tail count as a match
                            if (w_empty) begin
                                n_rsp.status = ST_EMPTY;
                            end else if (!w_hit[r_count]) begin
                                n_rsp.status = ST_NOTFOUND;
                            end else begin
                                w_ctl.rm = 1'b1;
                                n_count  = r_count - CNT_W'(1);
                            end
                        end
                        FN_DUMP: begin
                            if (w_empty) begin
                                n_rsp.status = ST_EMPTY;
                            end else begin
                                n_state     = S_DUMP;
                                n_idx       = '0;
                                n_rsp_valid = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_rsp.occupancy = 5'(n_count);
                end
            end
            S_DUMP: begin
                if (w_free) begin
                    w_ctl.rot       = 1'b1;
                    n_rsp.status    = ST_OK;
                    n_rsp.entry     = w_data[0];
                    n_rsp.occupancy = 5'(r_count);
                    n_rsp.last      = w_dump_last;
                    n_rsp_valid     = 1'b1;
                    n_idx           = r_idx + CNT_W'(1);
                    if (w_dump_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        if (w_acc) begin
            r_func <= i_req.func;
            r_val  <= i_req.value;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("occupancy above depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 (r_count == $past(r_count) || r_count == $past(r_count) + CNT_W'(1)
             || r_count == $past(r_count) - CNT_W'(1)))
        else $error("occupancy moved by more than one");

    a_dump_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |-> (r_idx < r_count))
        else $error("dump index beyond held entries");

    a_full_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && r_rsp.status == ST_FULL) |-> w_full)
        else $error("full status with room left");

    a_empty_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && r_rsp.status == ST_EMPTY) |-> w_empty)
        else $error("empty status with entries held");
`endif

endmodule
